>>> design/tlv_stream_deframer_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef TLV_STREAM_DEFRAMER_ASSERT_SVH
`define TLV_STREAM_DEFRAMER_ASSERT_SVH

// expr must hold at every clock edge outside reset
`define TLVDF_ASSERT_HOLD(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define TLVDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/tlvdf_pkg.sv
// Types and constants of the TLV stream deframer.
package tlvdf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 32;
  localparam int unsigned SeenW = 3;
  localparam int unsigned PhaseW = 2;

  localparam logic [PhaseW-1:0] PH_TYPE    = 2'd0;
  localparam logic [PhaseW-1:0] PH_LEN     = 2'd1;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 2'd2;

  localparam logic [SeenW-1:0] LEN_BYTES = 3'd4;

  typedef struct packed {
    logic             empty_message;
    logic             last_of_message;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] message_type;
  } tlv_result_t;

endpackage

>>> design/tlvdf_core.sv
// Input register and record-parsing state; one byte decoded per cycle unless the result side stalls.
module tlvdf_core
  import tlvdf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ByteW-1:0]     in_byte,
  output logic                 res_valid,
  input  logic                 res_ready,
  output tlv_result_t          res
);

  logic              held_valid;
  logic [ByteW-1:0]  held_byte;
  logic              advance;

  logic [PhaseW-1:0] phase, phase_next;
  logic [SeenW-1:0]  seen, seen_next;
  logic [ByteW-1:0]  cur_type, cur_type_next;
  logic [LenW-1:0]   remaining, remaining_next;
  logic              has_result;

  logic [LenW-1:0]   rem_shift;
  logic [LenW-1:0]   rem_dec;
  logic [SeenW-1:0]  seen_inc;

  assign rem_shift = {remaining[LenW-ByteW-1:0], held_byte};
  assign rem_dec   = remaining - LenW'(1);
  assign seen_inc  = seen + SeenW'(1);

  always_comb begin
    phase_next     = phase;
    seen_next      = seen;
    cur_type_next  = cur_type;
    remaining_next = remaining;
    has_result     = 1'b0;
    res.message_type    = cur_type;
    res.payload_byte    = '0;
    res.last_of_message = 1'b0;
    res.empty_message   = 1'b0;
    case (phase)
      PH_LEN: begin
        remaining_next = rem_shift;
        if (seen_inc != '0 && seen_inc < LEN_BYTES) begin
          seen_next = seen_inc;
        end else begin
          seen_next = '0;
          if (rem_shift == '0) begin
            phase_next          = PH_TYPE;
            has_result          = 1'b1;
            res.last_of_message = 1'b1;
            res.empty_message   = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        remaining_next   = rem_dec;
        has_result       = 1'b1;
        res.payload_byte = held_byte;
        if (rem_dec == '0) begin
          phase_next          = PH_TYPE;
          res.last_of_message = 1'b1;
        end
      end
      default: begin
        cur_type_next  = held_byte;
        seen_next      = '0;
        remaining_next = '0;
        phase_next     = PH_LEN;
      end
    endcase
  end

  assign advance   = held_valid && (res_ready || !has_result);
  assign in_ready  = !held_valid || advance;
  assign res_valid = held_valid && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      phase      <= PH_TYPE;
      seen       <= '0;
      cur_type   <= '0;
      remaining  <= '0;
    end else begin
      if (in_ready) begin
        held_valid <= in_valid;
      end
      if (advance) begin
        phase     <= phase_next;
        seen      <= seen_next;
        cur_type  <= cur_type_next;
        remaining <= remaining_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

endmodule

>>> design/tlvdf_skid.sv
// Result register with a skid stage that absorbs one result under back-pressure before the core stalls.
module tlvdf_skid
  import tlvdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  tlv_result_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output tlv_result_t  out_data
);

  logic        skid_valid;
  tlv_result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

>>> design/tlv_stream_deframer.sv
// Top level of the TLV stream deframer.
//
//  channel  dir  tdata                                     tlast            tuser
//  s_axis   in   [7:0] data_byte                           -                -
//  m_axis   out  [7:0] message_type, [15:8] payload_byte   last_of_message  empty_message
//
// One input beat per cycle unless m_axis stalls; each result is registered in the skid stage.
// The rate is set by the combinational parse step between input and result registers.
// Type and length bytes give no result; each payload byte and each empty record give one.
// rst is synchronous; it returns the parser to expecting a type byte.
// Output stalls are absorbed by a skid stage, then back up to s_axis_tready.
module tlv_stream_deframer
  import tlvdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] message_type, [15:8] payload_byte
  output logic        m_axis_tlast,   // last_of_message
  output logic        m_axis_tuser    // [0] empty_message
);

  `include "tlv_stream_deframer_assert.svh"

  logic        res_valid;
  logic        res_ready;
  tlv_result_t res;
  tlv_result_t out_res;

  tlvdf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  tlvdf_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {out_res.payload_byte, out_res.message_type};
  assign m_axis_tlast = out_res.last_of_message;
  assign m_axis_tuser = out_res.empty_message;

  `TLVDF_ASSERT_HOLD(a_empty_is_last,
    !(m_axis_tvalid && m_axis_tuser) || (m_axis_tlast && m_axis_tdata[15:8] == 8'd0),
    "empty record beat without last or with non-zero payload")

  `TLVDF_ASSERT_HOLD(a_skid_implies_out, res_ready || m_axis_tvalid,
    "skid stage full while result register empty")

  `TLVDF_ASSERT_NEXT(a_drain_frees_skid, !res_ready && m_axis_tready, res_ready,
    "skid stage not emptied after result taken")

endmodule

>>> tb/tlv_deframer_checker.sv
// Checker for the TLV stream deframer: tracks record parsing and compares output beats.
module tlv_deframer_checker
  import tlvdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        m_tlast,
  input  logic        m_tuser,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PhaseW-1:0] rec_phase;
  logic [SeenW-1:0]  len_seen;
  logic [ByteW-1:0]  rec_type;
  logic [LenW-1:0]   rec_left;
  tlv_result_t       tagged_beats[$];

  // advances the parse by one byte; returns 1 when a tagged beat is due
  function automatic bit parse_byte(input logic [ByteW-1:0] b, output tlv_result_t r);
    r = '0;
    r.message_type = rec_type;
    case (rec_phase)
      PH_LEN: begin
        rec_left = {rec_left[LenW-ByteW-1:0], b};
        len_seen = len_seen + 1'b1;
        if (len_seen < LEN_BYTES && len_seen != '0) return 1'b0;
        len_seen = '0;
        if (rec_left == '0) begin
          rec_phase = PH_TYPE;
          r.last_of_message = 1'b1;
          r.empty_message = 1'b1;
          return 1'b1;
        end
        rec_phase = PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        rec_left = rec_left - 1'b1;
        r.payload_byte = b;
        if (rec_left == '0) begin
          rec_phase = PH_TYPE;
          r.last_of_message = 1'b1;
        end
        return 1'b1;
      end
      default: begin
        // unused phase code behaves as a type byte
        rec_type = b;
        len_seen = '0;
        rec_left = '0;
        rec_phase = PH_LEN;
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    tlv_result_t want;
    tlv_result_t got;
    if (rst) begin
      rec_phase = PH_TYPE;
      len_seen = '0;
      rec_type = '0;
      rec_left = '0;
      tagged_beats.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (parse_byte(s_tdata, want)) tagged_beats.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tlast, m_tdata[15:8], m_tdata[7:0]};
        if (tagged_beats.size() == 0) begin
          $error("unexpected beat: tdata %h tlast %b tuser %b", m_tdata, m_tlast, m_tuser);
          errors++;
        end else begin
          want = tagged_beats.pop_front();
          if (got.message_type !== want.message_type) begin
            $error("message_type: expected %h, got %h", want.message_type, got.message_type);
            errors++;
          end
          if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %h, got %h", want.payload_byte, got.payload_byte);
            errors++;
          end
          if (got.last_of_message !== want.last_of_message) begin
            $error("last_of_message: expected %b, got %b",
                   want.last_of_message, got.last_of_message);
            errors++;
          end
          if (got.empty_message !== want.empty_message) begin
            $error("empty_message: expected %b, got %b", want.empty_message, got.empty_message);
            errors++;
          end
        end
      end
      pending = tagged_beats.size();
    end
  end

endmodule

>>> tb/tlv_stream_deframer_tb.sv
// Testbench top for the TLV stream deframer: record stimulus, flow control and verdict.
module tlv_stream_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlvdf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = '0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [15:0] m_tdata;
  wire         m_tlast;
  wire         m_tuser;

  int mismatches;
  int beats_waiting;
  int sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  tlv_stream_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .m_axis_tuser  (m_tuser)
  );

  tlv_deframer_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .errors   (mismatches),
    .pending  (beats_waiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // type, big-endian length, then body_len random payload bytes
  task automatic send_record(input logic [7:0] rtype, input logic [31:0] len, input int body_len);
    send_byte(rtype);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
    repeat (body_len) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    logic [31:0] len;
    int pick;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty record, single-byte record, two-byte record at the byte extremes
    send_record(8'hFF, 32'd0, 0);
    send_record(8'h00, 32'd1, 0);
    send_byte(8'hFF);
    send_record(8'hA5, 32'd2, 0);
    send_byte(8'h00);
    send_byte(8'h80);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_left = 80;
        end
        1: begin
          send_idle_pct = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_idle_pct = 20;
          recv_stall_pct = 20;
        end
      endcase
      while (sent < (p + 1) * 400 + 18) begin
        pick = $urandom_range(99);
        if (pick < 10) len = 32'd0;
        else if (pick < 80) len = 32'($urandom_range(8, 1));
        else if (pick < 95) len = 32'($urandom_range(40, 9));
        else len = 32'($urandom_range(300, 256));
        send_record(8'($urandom_range(255)), len, int'(len));
      end
    end

    // maximal length: never completes, payload beats carry no last
    send_idle_pct = 0;
    send_record(8'h5A, 32'hFFFF_FFFF, 3);
    s_tvalid <= 1'b0;
    recv_stall_pct = 0;

    @(posedge clk);
    wait (beats_waiting == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/tlvdf_pkg.sv
design/tlvdf_core.sv
design/tlvdf_skid.sv
design/tlv_stream_deframer.sv
tb/tlv_deframer_checker.sv
tb/tlv_stream_deframer_tb.sv
